@@ rtl/core/rdbf_pkg.sv @@
// ----------------------------------------------------------------------------
// rdbf_pkg
// Types and constants shared by the ramp deblocking edge filter core.
// ----------------------------------------------------------------------------
package rdbf_pkg;

  localparam int FIELD_W    = 48;  // width of one packed pixel field
  localparam int STRENGTH_W = 10;
  localparam int COUNT_W    = 3;
  localparam int DEPTH_W    = 3;
  localparam int BASE_BITS  = 8;   // bit depth at extra_bit_depth zero

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd2;

  typedef enum logic {
    CMD_LUMA   = 1'b0,
    CMD_CHROMA = 1'b1
  } rdbf_cmd_e;

  typedef struct packed {
    rdbf_cmd_e             cmd;
    logic [STRENGTH_W-1:0] strength;
    logic [DEPTH_W-1:0]    depth;  // extra bit depth, already saturated
  } rdbf_ctrl_t;

endpackage

@@ rtl/core/rdbf_lane.sv @@
// ----------------------------------------------------------------------------
// rdbf_lane
// Two-stage filter for one line across the edge: edge metric, then ramp,
// outer-pixel correction and clipping.
// ----------------------------------------------------------------------------
module rdbf_lane
  import rdbf_pkg::*;
#(
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  rdbf_ctrl_t            ctrl_i,
  input  logic [PIXEL_BITS-1:0] pix_a_i,
  input  logic [PIXEL_BITS-1:0] pix_b_i,
  input  logic [PIXEL_BITS-1:0] pix_c_i,
  input  logic [PIXEL_BITS-1:0] pix_d_i,
  output logic [PIXEL_BITS-1:0] pix_a_o,
  output logic [PIXEL_BITS-1:0] pix_b_o,
  output logic [PIXEL_BITS-1:0] pix_c_o,
  output logic [PIXEL_BITS-1:0] pix_d_o
);

  localparam int P  = PIXEL_BITS;
  localparam int SW = P + 4;                                  // edge sum
  localparam int RW = ((P > STRENGTH_W) ? P : STRENGTH_W) + 3; // ramp math
  localparam int VW = P + 2;                                  // pre-clip

  function automatic logic [P-1:0] clip_pix(input logic signed [VW-1:0] v,
                                            input logic [P-1:0] hi);
    logic signed [VW-1:0] hi_s;
    hi_s = $signed({2'b00, hi});
    if (v < 0) begin
      clip_pix = '0;
    end else if (v > hi_s) begin
      clip_pix = hi;
    end else begin
      clip_pix = v[P-1:0];
    end
  endfunction

  // stage 1: edge metric
  logic signed [SW-1:0] sum;
  logic        [SW-1:0] abs_sum;
  logic signed [P:0]    diff;
  logic        [P:0]    abs_diff;

  always_comb begin
    sum = $signed({4'b0000, pix_a_i}) + ($signed({4'b0000, pix_c_i}) <<< 2)
        - ($signed({4'b0000, pix_b_i}) <<< 2) - $signed({4'b0000, pix_d_i});
    abs_sum  = sum[SW-1] ? SW'(-sum) : SW'(sum);
    diff     = $signed({1'b0, pix_a_i}) - $signed({1'b0, pix_d_i});
    abs_diff = diff[P] ? (P+1)'(-diff) : (P+1)'(diff);
  end

  logic [P-1:0] a1_q, b1_q, c1_q, d1_q;
  logic [P-1:0] mag1_q;
  logic [P-2:0] adiff1_q;
  logic         neg1_q, dneg1_q, en1_q;
  rdbf_ctrl_t   ctrl1_q;

  always_ff @(posedge clk_i) begin
    a1_q     <= pix_a_i;
    b1_q     <= pix_b_i;
    c1_q     <= pix_c_i;
    d1_q     <= pix_d_i;
    mag1_q   <= abs_sum[P+2:3];  // |sum| / 8 toward zero
    adiff1_q <= abs_diff[P:2];
    neg1_q   <= sum[SW-1];
    dneg1_q  <= diff[P];
    en1_q    <= en_i;
    ctrl1_q  <= ctrl_i;
  end

  // stage 2: ramp, correction, clip
  logic signed [RW-1:0] over;
  logic signed [RW-1:0] excess;
  logic signed [RW-1:0] ramp_s;
  logic        [P-1:0]  ramp;
  logic        [P-2:0]  m2;
  logic        [P:0]    one_sh;
  logic        [P-1:0]  hi;
  logic signed [VW-1:0] ramp_v, m2_v, nb, nc, na, nd;
  logic        [P-1:0]  a_d, b_d, c_d, d_d;

  always_comb begin
    over   = $signed(RW'(mag1_q)) - $signed(RW'(ctrl1_q.strength));
    excess = (over > 0) ? (over <<< 1) : '0;
    ramp_s = $signed(RW'(mag1_q)) - excess;
    ramp   = (ramp_s < 0) ? '0 : ramp_s[P-1:0];
    m2     = (adiff1_q < ramp[P-1:1]) ? adiff1_q : ramp[P-1:1];

    one_sh = (P+1)'(1) << ({1'b0, ctrl1_q.depth} + 4'(BASE_BITS));
    hi     = P'(one_sh - (P+1)'(1));

    ramp_v = $signed(VW'(ramp));
    m2_v   = $signed(VW'(m2));
    nb = neg1_q  ? $signed(VW'(b1_q)) - ramp_v : $signed(VW'(b1_q)) + ramp_v;
    nc = neg1_q  ? $signed(VW'(c1_q)) + ramp_v : $signed(VW'(c1_q)) - ramp_v;
    na = dneg1_q ? $signed(VW'(a1_q)) + m2_v   : $signed(VW'(a1_q)) - m2_v;
    nd = dneg1_q ? $signed(VW'(d1_q)) - m2_v   : $signed(VW'(d1_q)) + m2_v;

    a_d = a1_q;
    b_d = b1_q;
    c_d = c1_q;
    d_d = d1_q;
    if (en1_q) begin
      b_d = clip_pix(nb, hi);
      c_d = clip_pix(nc, hi);
      if (ctrl1_q.cmd == CMD_LUMA) begin
        a_d = clip_pix(na, hi);
        d_d = clip_pix(nd, hi);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pix_a_o <= a_d;
    pix_b_o <= b_d;
    pix_c_o <= c_d;
    pix_d_o <= d_d;
  end

endmodule

@@ rtl/core/rdbf_merge.sv @@
// ----------------------------------------------------------------------------
// rdbf_merge
// Gathers the lane pixels back into packed fields and drives the result
// register and its strobe.
// ----------------------------------------------------------------------------
module rdbf_merge
  import rdbf_pkg::*;
#(
  parameter int LINES      = 4,
  parameter int PIXEL_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [LINES-1:0][PIXEL_BITS-1:0]     lane_a_i,
  input  logic [LINES-1:0][PIXEL_BITS-1:0]     lane_b_i,
  input  logic [LINES-1:0][PIXEL_BITS-1:0]     lane_c_i,
  input  logic [LINES-1:0][PIXEL_BITS-1:0]     lane_d_i,
  output logic                                 result_valid_o,
  output logic [FIELD_W-1:0]                   far_before_result_o,
  output logic [FIELD_W-1:0]                   near_before_result_o,
  output logic [FIELD_W-1:0]                   near_after_result_o,
  output logic [FIELD_W-1:0]                   far_after_result_o
);

  localparam int PW = LINES * PIXEL_BITS;

  logic [PW-1:0] word_a, word_b, word_c, word_d;

  // line 0 lands in the low bits, anything past the field width is dropped
  assign word_a = lane_a_i;
  assign word_b = lane_b_i;
  assign word_c = lane_c_i;
  assign word_d = lane_d_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    far_before_result_o  <= FIELD_W'(word_a);
    near_before_result_o <= FIELD_W'(word_b);
    near_after_result_o  <= FIELD_W'(word_c);
    far_after_result_o   <= FIELD_W'(word_d);
  end

endmodule

@@ rtl/core/ramp_deblocking_edge_filter_core.sv @@
// ----------------------------------------------------------------------------
// ramp_deblocking_edge_filter_core
// Ramp deblocking filter for one edge segment of up to LINES lines.
// ----------------------------------------------------------------------------
// Takes one edge segment per clock: busy_o stays low, so an item is taken at
// every edge where start_i is high. Each line runs in its own lane, a
// two-stage pipeline (edge metric, then ramp and clipping), and a merge
// register packs the lanes; each result passes the lane registers and the
// merge register and is strobed by result_valid_o for one cycle.
// The receiver cannot hold results off and must take each one as it comes.
// cfg_we_i writes the extra bit depth; write it only while no item is in
// flight.
module ramp_deblocking_edge_filter_core
  import rdbf_pkg::*;
#(
  parameter int LINES      = 4,
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DEPTH_W-1:0]    cfg_wdata_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  cmd_i,
  input  logic [STRENGTH_W-1:0] strength_i,
  input  logic [COUNT_W-1:0]    line_count_i,
  input  logic [FIELD_W-1:0]    far_before_pixels_i,
  input  logic [FIELD_W-1:0]    near_before_pixels_i,
  input  logic [FIELD_W-1:0]    near_after_pixels_i,
  input  logic [FIELD_W-1:0]    far_after_pixels_i,
  output logic                  result_valid_o,
  output logic [FIELD_W-1:0]    far_before_result_o,
  output logic [FIELD_W-1:0]    near_before_result_o,
  output logic [FIELD_W-1:0]    near_after_result_o,
  output logic [FIELD_W-1:0]    far_after_result_o
);

  localparam int PW = LINES * PIXEL_BITS;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(PIXEL_BITS - BASE_BITS);

  logic [DEPTH_W-1:0] depth_q;
  logic               accept;
  logic               v1_q, v2_q;
  rdbf_ctrl_t         ctrl;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      depth_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    ctrl.cmd      = rdbf_cmd_e'(cmd_i);
    ctrl.strength = strength_i;
    ctrl.depth    = (depth_q > MAX_DEPTH) ? MAX_DEPTH : depth_q;
  end

  // fields resized to the lane span, upper bits read as zero
  logic [LINES-1:0][PIXEL_BITS-1:0] in_a, in_b, in_c, in_d;
  logic [LINES-1:0][PIXEL_BITS-1:0] out_a, out_b, out_c, out_d;

  assign in_a = PW'(far_before_pixels_i);
  assign in_b = PW'(near_before_pixels_i);
  assign in_c = PW'(near_after_pixels_i);
  assign in_d = PW'(far_after_pixels_i);

  for (genvar i = 0; i < LINES; i++) begin : g_lane
    logic lane_en;
    assign lane_en = (strength_i != '0) && (COUNT_W'(i) < line_count_i);

    rdbf_lane #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (lane_en),
      .ctrl_i (ctrl),
      .pix_a_i(in_a[i]),
      .pix_b_i(in_b[i]),
      .pix_c_i(in_c[i]),
      .pix_d_i(in_d[i]),
      .pix_a_o(out_a[i]),
      .pix_b_o(out_b[i]),
      .pix_c_o(out_c[i]),
      .pix_d_o(out_d[i])
    );
  end

  rdbf_merge #(
    .LINES     (LINES),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_merge (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (v2_q),
    .lane_a_i            (out_a),
    .lane_b_i            (out_b),
    .lane_c_i            (out_c),
    .lane_d_i            (out_d),
    .result_valid_o      (result_valid_o),
    .far_before_result_o (far_before_result_o),
    .near_before_result_o(near_before_result_o),
    .near_after_result_o (near_after_result_o),
    .far_after_result_o  (far_after_result_o)
  );

  // every item comes out as a result strobe, and nothing else does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 result_valid_o)
    else $error("item accepted but no result three cycles later");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 3))
    else $error("result strobe without an item");

  // zero strength passes all fields through (checked on near before and far after)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && strength_i == '0) |-> ##3
      (near_before_result_o == $past(FIELD_W'(PW'(near_before_pixels_i)), 3)) &&
      (far_after_result_o == $past(FIELD_W'(PW'(far_after_pixels_i)), 3)))
    else $error("zero strength item was changed");

  // chroma leaves the outer pixels alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_CHROMA) |-> ##3
      (far_before_result_o == $past(FIELD_W'(PW'(far_before_pixels_i)), 3)))
    else $error("chroma item changed an outer pixel");

endmodule
